// ===== rtl/wof_pkg.sv =====
// shared types and constants of the second-order washout filter
`timescale 1ns / 1ps

package wof_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int LIMIT_W   = 31;
   localparam int COEF_W    = 32;
   localparam int MAG_W     = 42;
   localparam int PROD_W    = MAG_W + COEF_W;
   localparam int RND_W     = PROD_W - 16;
   localparam int TERM_W    = RND_W + 1;
   localparam int CNT_W     = $clog2(COEF_W);
   localparam int CSR_IDX_W = 3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [COEF_W-1:0]          coef_type;
   typedef logic [LIMIT_W-1:0]         limit_type;
   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;
   typedef logic signed [TERM_W-1:0]   term_type;

   // register indexes
   localparam csr_idx_type REG_ACC_LIMIT      = 3'd0;
   localparam csr_idx_type REG_FEEDBACK_GAIN  = 3'd1;
   localparam csr_idx_type REG_NORMALIZE_GAIN = 3'd2;
   localparam csr_idx_type REG_STEP_SQ        = 3'd3;
   localparam csr_idx_type REG_INV_STEP_SQ    = 3'd4;

   // register reset values
   localparam limit_type RST_ACC_LIMIT      = 31'd642253;
   localparam coef_type  RST_FEEDBACK_GAIN  = 32'd66437775;
   localparam coef_type  RST_NORMALIZE_GAIN = 32'd5649275;
   localparam coef_type  RST_STEP_SQ        = 32'd6711;
   localparam coef_type  RST_INV_STEP_SQ    = 32'd163840000;

   // multiply steps of one item
   localparam logic [1:0] OP_FEEDBACK  = 2'd0;
   localparam logic [1:0] OP_DRIVE     = 2'd1;
   localparam logic [1:0] OP_NORMALIZE = 2'd2;
   localparam logic [1:0] OP_REALIZED  = 2'd3;

   // clip a rounded term to the signed sample range
   function automatic sample_type sat_sample(input term_type v);
      logic [TERM_W-SAMPLE_W:0] upper;
      sample_type               res;
      upper = v[TERM_W-1:SAMPLE_W-1];
      if (upper == '0 || upper == '1) begin
         res = v[SAMPLE_W-1:0];
      end else if (v[TERM_W-1]) begin
         res = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

// ===== rtl/wof_if.sv =====
// channel interfaces of the second-order washout filter
`timescale 1ns / 1ps

interface wof_req_if import wof_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type acc;
   modport source (output valid, output acc, input ready);
   modport sink (input valid, input acc, output ready);
endinterface

interface wof_rsp_if import wof_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type position;
   sample_type real_acc;
   modport source (output valid, output position, output real_acc, input ready);
   modport sink (input valid, input position, input real_acc, output ready);
endinterface

interface wof_csr_if import wof_pkg::*; ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   coef_type    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/washout_filter_second_order_core.sv =====
// second-order washout filter core, one axis, bit-serial multiply
`timescale 1ns / 1ps

// One acceleration sample in, one position and realized acceleration out.
// The four products of an item (feedback, drive, normalize, realized
// acceleration) run one after another on a single shift-add multiplier that
// takes one coefficient bit per cycle, so each product is a pass over all
// coefficient bits plus load, sign, round and accumulate steps. An item is
// finished before the next sample is taken. A new sample is taken while
// the previous result still waits on the rsp channel. Configuration writes
// are taken at any time and must be made while the block is idle.

module washout_filter_second_order_core import wof_pkg::*; (
   input logic        clock,
   input logic        reset,
   wof_req_if.sink    req_ch,
   wof_rsp_if.source  rsp_ch,
   wof_csr_if.sink    csr_ch
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_ABS  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_RND  = 3'd4;
   localparam logic [2:0] ST_ACC  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [1:0]               op_ff, op_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   limit_type                acc_limit_ff, acc_limit_in;
   coef_type                 feedback_gain_ff, feedback_gain_in;
   coef_type                 normalize_gain_ff, normalize_gain_in;
   coef_type                 step_sq_ff, step_sq_in;
   coef_type                 inv_step_sq_ff, inv_step_sq_in;

   sample_type               pos_last_ff, pos_last_in;
   sample_type               pos_before_last_ff, pos_before_last_in;

   sample_type               acc_ff, acc_in;
   logic signed [MAG_W-1:0]  opnd_ff, opnd_in;
   logic signed [MAG_W-1:0]  sum_ff, sum_in;
   logic                     sign_ff, sign_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   coef_type                 coef_ff, coef_in;
   logic [MAG_W-1:0]         hi_ff, hi_in;
   logic [COEF_W-1:0]        lo_ff, lo_in;
   term_type                 term_ff, term_in;
   sample_type               pos_ff, pos_in;
   sample_type               racc_ff, racc_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   sample_type               rsp_position_ff, rsp_position_in;
   sample_type               rsp_real_acc_ff, rsp_real_acc_in;

   logic                     req_fire;
   logic                     out_free;
   sample_type               limit_pos;
   sample_type               limit_neg;
   logic [MAG_W:0]           mul_sum;
   logic [PROD_W-1:0]        prod;
   logic [RND_W-1:0]         rmag;

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.position = rsp_position_ff;
   assign rsp_ch.real_acc = rsp_real_acc_ff;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign limit_pos = {1'b0, acc_limit_ff};
   assign limit_neg = -limit_pos;
   assign mul_sum   = {1'b0, hi_ff} + (coef_ff[0] ? {1'b0, mag_ff} : '0);
   assign prod      = {hi_ff, lo_ff};

   always_comb begin
      if (op_ff == OP_REALIZED) begin
         rmag = prod[PROD_W-1:16] + RND_W'(prod[15]);
      end else begin
         rmag = RND_W'(prod[PROD_W-1:24]) + RND_W'(prod[23]);
      end
   end

   // configuration writes
   always_comb begin
      acc_limit_in      = acc_limit_ff;
      feedback_gain_in  = feedback_gain_ff;
      normalize_gain_in = normalize_gain_ff;
      step_sq_in        = step_sq_ff;
      inv_step_sq_in    = inv_step_sq_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            REG_ACC_LIMIT:      acc_limit_in      = csr_ch.data[LIMIT_W-1:0];
            REG_FEEDBACK_GAIN:  feedback_gain_in  = csr_ch.data;
            REG_NORMALIZE_GAIN: normalize_gain_in = csr_ch.data;
            REG_STEP_SQ:        step_sq_in        = csr_ch.data;
            REG_INV_STEP_SQ:    inv_step_sq_in    = csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   // sequencer and datapath
   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      cnt_in             = cnt_ff;
      pos_last_in        = pos_last_ff;
      pos_before_last_in = pos_before_last_ff;
      acc_in             = acc_ff;
      opnd_in            = opnd_ff;
      sum_in             = sum_ff;
      sign_in            = sign_ff;
      mag_in             = mag_ff;
      coef_in            = coef_ff;
      hi_in              = hi_ff;
      lo_in              = lo_ff;
      term_in            = term_ff;
      pos_in             = pos_ff;
      racc_in            = racc_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ch.ready;
      rsp_position_in    = rsp_position_ff;
      rsp_real_acc_in    = rsp_real_acc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_ch.acc > limit_pos) begin
                  acc_in = limit_pos;
               end else if (req_ch.acc < limit_neg) begin
                  acc_in = limit_neg;
               end else begin
                  acc_in = req_ch.acc;
               end
               op_in    = OP_FEEDBACK;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            unique case (op_ff)
               OP_FEEDBACK: begin
                  opnd_in = MAG_W'(pos_last_ff);
                  coef_in = feedback_gain_ff;
               end
               OP_DRIVE: begin
                  opnd_in = MAG_W'(acc_ff);
                  coef_in = step_sq_ff;
               end
               OP_NORMALIZE: begin
                  opnd_in = sum_ff;
                  coef_in = normalize_gain_ff;
               end
               OP_REALIZED: begin
                  opnd_in = MAG_W'(pos_ff) - (MAG_W'(pos_last_ff) <<< 1)
                          + MAG_W'(pos_before_last_ff);
                  coef_in = inv_step_sq_ff;
               end
               default: begin
               end
            endcase
            state_in = ST_ABS;
         end
         ST_ABS: begin
            sign_in  = opnd_ff[MAG_W-1];
            mag_in   = opnd_ff[MAG_W-1] ? MAG_W'(-opnd_ff) : MAG_W'(opnd_ff);
            hi_in    = '0;
            lo_in    = '0;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            hi_in   = mul_sum[MAG_W:1];
            lo_in   = {mul_sum[0], lo_ff[COEF_W-1:1]};
            coef_in = coef_ff >> 1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            term_in  = sign_ff ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
            state_in = ST_ACC;
         end
         ST_ACC: begin
            unique case (op_ff)
               OP_FEEDBACK:  sum_in  = MAG_W'(term_ff) - MAG_W'(pos_before_last_ff);
               OP_DRIVE:     sum_in  = sum_ff + MAG_W'(term_ff);
               OP_NORMALIZE: pos_in  = sat_sample(term_ff);
               OP_REALIZED:  racc_in = sat_sample(term_ff);
               default: begin
               end
            endcase
            if (op_ff == OP_REALIZED) begin
               state_in = ST_OUT;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_position_in    = pos_ff;
               rsp_real_acc_in    = racc_ff;
               pos_before_last_in = pos_last_ff;
               pos_last_in        = pos_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         op_ff              <= OP_FEEDBACK;
         cnt_ff             <= '0;
         acc_limit_ff       <= RST_ACC_LIMIT;
         feedback_gain_ff   <= RST_FEEDBACK_GAIN;
         normalize_gain_ff  <= RST_NORMALIZE_GAIN;
         step_sq_ff         <= RST_STEP_SQ;
         inv_step_sq_ff     <= RST_INV_STEP_SQ;
         pos_last_ff        <= '0;
         pos_before_last_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         op_ff              <= op_in;
         cnt_ff             <= cnt_in;
         acc_limit_ff       <= acc_limit_in;
         feedback_gain_ff   <= feedback_gain_in;
         normalize_gain_ff  <= normalize_gain_in;
         step_sq_ff         <= step_sq_in;
         inv_step_sq_ff     <= inv_step_sq_in;
         pos_last_ff        <= pos_last_in;
         pos_before_last_ff <= pos_before_last_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff          <= acc_in;
      opnd_ff         <= opnd_in;
      sum_ff          <= sum_in;
      sign_ff         <= sign_in;
      mag_ff          <= mag_in;
      coef_ff         <= coef_in;
      hi_ff           <= hi_in;
      lo_ff           <= lo_in;
      term_ff         <= term_in;
      pos_ff          <= pos_in;
      racc_ff         <= racc_in;
      rsp_position_ff <= rsp_position_in;
      rsp_real_acc_ff <= rsp_real_acc_in;
   end

   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_LOAD && op_ff == OP_FEEDBACK))
      else $error("accepted sample did not start the feedback product");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside the output step");

   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=>
         (pos_before_last_ff == $past(pos_last_ff) && pos_last_ff == $past(pos_ff)))
      else $error("position history not shifted on result transfer");

   a_mul_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && cnt_ff != '1) |=> state_ff == ST_MUL)
      else $error("bit-serial multiply cut short");

endmodule
